@@ design/kwsm_pkg.sv @@
// Shared types and constants for the keyword substitution map unit.
package kwsm_pkg;

	localparam int MAP_DEPTH  = 256;
	localparam int IDX_W      = $clog2(MAP_DEPTH);
	localparam int SIZE_W     = $clog2(MAP_DEPTH + 1);
	localparam int DATA_W     = 8;
	localparam int KIND_W     = 3;
	localparam int STATUS_W   = 3;
	localparam int CFG_SIZE_W = 9;
	localparam int CFG_IDX_W  = 1;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_KEY   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FINAL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FWD   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INV   = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DUP       = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_READY = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0]   data;
		logic [STATUS_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic clear;
		logic key_load;
		logic walk_start;
		logic walk_step;
		logic lookup_read;
		logic res_simple;
		logic res_lookup;
		logic res_walk;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic lookup_ok;
		logic walk_last;
	} stat_t;

endpackage

@@ design/keyword_substitution_map_unit.sv @@
// Top level of the keyword substitution map unit: controller plus datapath.
// Builds a keyed substitution alphabet over alphabet_size consecutive byte values
// starting at alphabet_base (wrapping mod 256). Each input word carries a kind and
// a value and produces exactly one result word. Clear, key-byte and unused kinds,
// and a lookup that is refused (map not ready or offset too large), load their
// result straight from idle; an accepted forward or inverse lookup first does the
// registered read of the table RAM; finalize first runs a walk over eff_size
// offsets, where eff_size is alphabet_size clamped to 1..MAP_DEPTH, that visits
// one offset per cycle and writes both table RAMs. One word is in work at a time;
// the next word is taken as soon as the controller is back in idle and the result
// register is empty or being drained. A config write also clears the loaded key and
// the ready flag; cfg_ready is always high and writes are expected only while idle.
// The key bitmap sits in flops cleared at once, so there is no clearing pass after
// reset; table entries are undefined until a key load or finalize writes them.
module keyword_substitution_map_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// item channel
	input  logic                             item_valid,
	output logic                             item_stall,
	input  kwsm_pkg::item_t                  item,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output kwsm_pkg::result_t                result,
	// config write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kwsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kwsm_pkg::CFG_SIZE_W-1:0]  cfg_data
);

	kwsm_pkg::cmd_t  cmd;
	kwsm_pkg::stat_t stat;

	// register writes never wait
	assign cfg_ready = 1'b1;

	kwsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.kind      (item.kind),
		.stat      (stat),
		.cmd       (cmd),
		.item_stall(item_stall)
	);

	kwsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule

@@ design/kwsm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module kwsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/kwsm_ctrl.sv @@
// Controller state machine: sequences clear, key load, finalize walk and lookup.
module kwsm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic [kwsm_pkg::KIND_W-1:0]  kind,
	input  kwsm_pkg::stat_t              stat,
	output kwsm_pkg::cmd_t               cmd,
	output logic                         item_stall
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_LOOK = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign item_stall = !((state_q == ST_IDLE) && stat.out_free);
	assign take       = item_valid && !item_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (kind) inside
						kwsm_pkg::KIND_CLEAR: begin
							cmd.clear      = 1'b1;
							cmd.res_simple = 1'b1;
						end
						kwsm_pkg::KIND_KEY: begin
							cmd.key_load   = 1'b1;
							cmd.res_simple = 1'b1;
						end
						kwsm_pkg::KIND_FINAL: begin
							cmd.walk_start = 1'b1;
							state_d        = ST_WALK;
						end
						kwsm_pkg::KIND_FWD, kwsm_pkg::KIND_INV: begin
							if (stat.lookup_ok) begin
								cmd.lookup_read = 1'b1;
								state_d         = ST_LOOK;
							end else begin
								cmd.res_simple = 1'b1;
							end
						end
						default: begin
							cmd.res_simple = 1'b1;
						end
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_last) begin
					cmd.res_walk = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_LOOK: begin
				cmd.res_lookup = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/kwsm_dp.sv @@
// Datapath: config registers, key bookkeeping, finalize walk, tables and result register.
module kwsm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kwsm_pkg::item_t                  item,
	input  kwsm_pkg::cmd_t                   cmd,
	output kwsm_pkg::stat_t                  stat,
	input  logic                             cfg_valid,
	input  logic [kwsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kwsm_pkg::CFG_SIZE_W-1:0]  cfg_data,
	output kwsm_pkg::result_t                result,
	output logic                             result_valid,
	input  logic                             result_stall
);

	logic [kwsm_pkg::DATA_W-1:0]     base_q;
	logic [kwsm_pkg::CFG_SIZE_W-1:0] size_q;
	logic [kwsm_pkg::MAP_DEPTH-1:0]  used_q;
	logic [kwsm_pkg::SIZE_W-1:0]     key_len_q;
	logic                            ready_q;
	logic [kwsm_pkg::SIZE_W-1:0]     off_q;
	logic [kwsm_pkg::SIZE_W-1:0]     pos_q;
	logic                            sel_inv_q;
	kwsm_pkg::result_t               result_q;
	logic                            result_valid_q;

	logic [kwsm_pkg::SIZE_W-1:0]     eff_size;
	logic [kwsm_pkg::DATA_W-1:0]     key_off;
	logic                            key_in_range;
	logic                            key_dup;
	logic                            key_ok;
	logic                            val_in_range;
	logic                            walk_wr;
	logic                            clear_all;
	logic [kwsm_pkg::STATUS_W-1:0]   simple_status;

	logic                            fwd_we, inv_we;
	logic [kwsm_pkg::IDX_W-1:0]      fwd_waddr, inv_waddr;
	logic [kwsm_pkg::DATA_W-1:0]     fwd_wdata, inv_wdata;
	logic [kwsm_pkg::DATA_W-1:0]     fwd_rdata, inv_rdata;

	// size register clamped to 1..MAP_DEPTH
	always_comb begin
		if (size_q == '0) begin
			eff_size = kwsm_pkg::SIZE_W'(1);
		end else if (size_q > kwsm_pkg::CFG_SIZE_W'(kwsm_pkg::MAP_DEPTH)) begin
			eff_size = kwsm_pkg::SIZE_W'(kwsm_pkg::MAP_DEPTH);
		end else begin
			eff_size = kwsm_pkg::SIZE_W'(size_q);
		end
	end

	assign key_off      = item.value - base_q;
	assign key_in_range = {1'b0, key_off} < kwsm_pkg::CFG_SIZE_W'(eff_size);
	assign key_dup      = used_q[key_off[kwsm_pkg::IDX_W-1:0]];
	assign key_ok       = key_in_range && !key_dup &&
	                      (key_len_q < kwsm_pkg::SIZE_W'(kwsm_pkg::MAP_DEPTH));
	assign val_in_range = {1'b0, item.value} < kwsm_pkg::CFG_SIZE_W'(eff_size);
	assign walk_wr      = cmd.walk_step && !used_q[off_q[kwsm_pkg::IDX_W-1:0]];
	assign clear_all    = cmd.clear || cfg_valid;

	assign stat.out_free  = !result_valid_q || !result_stall;
	assign stat.lookup_ok = ready_q && val_in_range;
	assign stat.walk_last = off_q == (eff_size - kwsm_pkg::SIZE_W'(1));

	always_comb begin
		simple_status = kwsm_pkg::STAT_OK;
		unique case (item.kind) inside
			kwsm_pkg::KIND_KEY: begin
				if (!key_in_range) begin
					simple_status = kwsm_pkg::STAT_RANGE;
				end else if (key_dup) begin
					simple_status = kwsm_pkg::STAT_DUP;
				end
			end
			kwsm_pkg::KIND_FWD, kwsm_pkg::KIND_INV: begin
				if (!ready_q) begin
					simple_status = kwsm_pkg::STAT_NOT_READY;
				end else if (!val_in_range) begin
					simple_status = kwsm_pkg::STAT_TOO_LARGE;
				end
			end
			default: begin
				simple_status = kwsm_pkg::STAT_OK;
			end
		endcase
	end

	// table write ports: key load or finalize walk
	assign fwd_we    = (cmd.key_load && key_ok) || walk_wr;
	assign inv_we    = fwd_we;
	assign fwd_waddr = cmd.key_load ? key_len_q[kwsm_pkg::IDX_W-1:0]
	                                : pos_q[kwsm_pkg::IDX_W-1:0];
	assign fwd_wdata = cmd.key_load ? item.value
	                                : base_q + kwsm_pkg::DATA_W'(off_q);
	assign inv_waddr = cmd.key_load ? key_off[kwsm_pkg::IDX_W-1:0]
	                                : off_q[kwsm_pkg::IDX_W-1:0];
	assign inv_wdata = cmd.key_load ? kwsm_pkg::DATA_W'(key_len_q)
	                                : kwsm_pkg::DATA_W'(pos_q);

	kwsm_ram #(
		.WIDTH(kwsm_pkg::DATA_W),
		.DEPTH(kwsm_pkg::MAP_DEPTH)
	) u_fwd_ram (
		.clk  (clk),
		.we   (fwd_we),
		.waddr(fwd_waddr),
		.wdata(fwd_wdata),
		.re   (cmd.lookup_read),
		.raddr(item.value[kwsm_pkg::IDX_W-1:0]),
		.rdata(fwd_rdata)
	);

	kwsm_ram #(
		.WIDTH(kwsm_pkg::DATA_W),
		.DEPTH(kwsm_pkg::MAP_DEPTH)
	) u_inv_ram (
		.clk  (clk),
		.we   (inv_we),
		.waddr(inv_waddr),
		.wdata(inv_wdata),
		.re   (cmd.lookup_read),
		.raddr(item.value[kwsm_pkg::IDX_W-1:0]),
		.rdata(inv_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			size_q    <= kwsm_pkg::CFG_SIZE_W'(256);
			used_q    <= '0;
			key_len_q <= '0;
			ready_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					kwsm_pkg::CFG_BASE: base_q <= cfg_data[kwsm_pkg::DATA_W-1:0];
					kwsm_pkg::CFG_SIZE: size_q <= cfg_data;
					default: ;
				endcase
			end
			if (clear_all) begin
				used_q    <= '0;
				key_len_q <= '0;
				ready_q   <= 1'b0;
			end else if (cmd.key_load && key_ok) begin
				used_q[key_off[kwsm_pkg::IDX_W-1:0]] <= 1'b1;
				key_len_q <= key_len_q + kwsm_pkg::SIZE_W'(1);
				ready_q   <= 1'b0;
			end else if (cmd.walk_step && stat.walk_last) begin
				ready_q <= 1'b1;
			end
		end
	end

	// walk counters and lookup select: payload only
	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			off_q <= '0;
			pos_q <= key_len_q;
		end else if (cmd.walk_step) begin
			off_q <= off_q + kwsm_pkg::SIZE_W'(1);
			if (walk_wr) begin
				pos_q <= pos_q + kwsm_pkg::SIZE_W'(1);
			end
		end
		if (cmd.lookup_read) begin
			sel_inv_q <= item.kind == kwsm_pkg::KIND_INV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.res_simple || cmd.res_lookup || cmd.res_walk) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_simple) begin
			result_q.data   <= '0;
			result_q.status <= simple_status;
		end else if (cmd.res_lookup) begin
			result_q.data   <= sel_inv_q ? inv_rdata : fwd_rdata;
			result_q.status <= kwsm_pkg::STAT_OK;
		end else if (cmd.res_walk) begin
			result_q.data   <= '0;
			result_q.status <= kwsm_pkg::STAT_OK;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

`ifndef SYNTHESIS
	a_key_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kwsm_pkg::CFG_SIZE_W'(key_len_q) <= kwsm_pkg::CFG_SIZE_W'(eff_size))
		else $error("key length exceeds alphabet size");

	a_walk_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		walk_wr |-> (kwsm_pkg::CFG_SIZE_W'(pos_q) < kwsm_pkg::CFG_SIZE_W'(kwsm_pkg::MAP_DEPTH)))
		else $error("finalize writes past table end");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_simple || cmd.res_lookup || cmd.res_walk) |-> stat.out_free)
		else $error("result loaded over a word still held");

	a_ready_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(cmd.walk_step && stat.walk_last))
		else $error("map ready set outside finalize");
`endif

endmodule
